>>> rtl/core/ufr_pkg.sv
package ufr_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hA5;
    localparam logic [7:0] TYPE_ERR = 8'h52;
    localparam logic [7:0] TYPE_ACK = 8'h12;
    localparam logic [7:0] TYPE_MSG = 8'h22;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [7:0] CSUM_INIT = 8'hFF;
    localparam logic [7:0] TYPE_LEN = 8'd3;

    typedef enum logic [2:0] {
        K_DATA      = 3'd0,
        K_OK        = 3'd1,
        K_CSUM_ERR  = 3'd2,
        K_ERR_RESP  = 3'd3,
        K_MALFORMED = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_HDR,
        S_TYPE,
        S_SEQ,
        S_LEN,
        S_ZERO,
        S_CSUM,
        S_BODY
    } t_state;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  data;
        logic        data_valid;
        logic [7:0]  payload_index;
        logic [7:0]  packet_type;
        logic [7:0]  sequence_res;
        logic [23:0] payload_type;
        logic [7:0]  payload_length;
        logic        ack_required;
        logic        ack_received;
        logic        plain_ack;
    } t_result;

endpackage

>>> rtl/core/ufr_parser.sv
module ufr_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    output ufr_pkg::t_result o_res
);
    import ufr_pkg::*;

    t_state      r_state, n_state;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_rx_csum, n_rx_csum;
    logic [7:0]  r_csum, n_csum;
    logic [23:0] r_ptype, n_ptype;

    logic        last;
    logic        in_payload;
    logic [7:0]  csum_sub;
    logic [23:0] ptype_sub;

    // body byte bookkeeping, valid while in S_BODY
    assign csum_sub   = r_csum - i_byte;
    assign ptype_sub  = (r_cnt < TYPE_LEN) ? {r_ptype[15:0], i_byte} : r_ptype;
    assign last       = ({1'b0, r_cnt} + 9'd1) >= {1'b0, r_len};
    assign in_payload = r_cnt >= TYPE_LEN;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_HDR: begin
                if (i_byte == HDR_BYTE) n_state = S_TYPE;
            end
            S_TYPE: begin
                if (i_byte inside {TYPE_ACK, TYPE_MSG}) n_state = S_SEQ;
                else n_state = S_HDR;
            end
            S_SEQ:  n_state = S_LEN;
            S_LEN:  n_state = S_ZERO;
            S_ZERO: begin
                if (i_byte == ZERO_BYTE) n_state = S_CSUM;
                else n_state = S_HDR;
            end
            S_CSUM: begin
                if (r_len == 8'd0) n_state = S_HDR;
                else n_state = S_BODY;
            end
            S_BODY: begin
                if (last) n_state = S_HDR;
            end
            default: n_state = S_HDR;
        endcase
    end

    // datapath and result
    always_comb begin
        n_cnt     = r_cnt;
        n_type    = r_type;
        n_seq     = r_seq;
        n_len     = r_len;
        n_rx_csum = r_rx_csum;
        n_csum    = r_csum;
        n_ptype   = r_ptype;
        o_res     = '0;
        o_res.kind = K_DATA;
        case (r_state)
            S_HDR: begin
                n_csum = CSUM_INIT - HDR_BYTE;
            end
            S_TYPE: begin
                if (i_byte == TYPE_ERR) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = K_ERR_RESP;
                end
                if (i_byte inside {TYPE_ACK, TYPE_MSG}) begin
                    n_type = i_byte;
                    n_csum = r_csum - i_byte;
                end
            end
            S_SEQ: begin
                n_seq  = i_byte;
                n_csum = r_csum - i_byte;
            end
            S_LEN: begin
                n_len  = i_byte;
                n_csum = r_csum - i_byte;
            end
            S_ZERO: begin
            end
            S_CSUM: begin
                n_rx_csum = i_byte;
                n_ptype   = '0;
                n_cnt     = '0;
                if (r_len == 8'd0) begin
                    o_res.valid        = 1'b1;
                    o_res.kind         = K_MALFORMED;
                    o_res.packet_type  = r_type;
                    o_res.sequence_res = r_seq;
                end
            end
            S_BODY: begin
                n_csum  = csum_sub;
                n_ptype = ptype_sub;
                n_cnt   = r_cnt + 8'd1;
                if (in_payload) begin
                    o_res.data          = i_byte;
                    o_res.data_valid    = 1'b1;
                    o_res.payload_index = r_cnt - TYPE_LEN;
                end
                if (!last) begin
                    o_res.valid = in_payload;
                end else if (r_len < TYPE_LEN) begin
                    // frame too short to hold the payload type
                    o_res              = '0;
                    o_res.valid        = 1'b1;
                    o_res.kind         = K_MALFORMED;
                    o_res.packet_type  = r_type;
                    o_res.sequence_res = r_seq;
                end else begin
                    o_res.valid          = 1'b1;
                    o_res.packet_type    = r_type;
                    o_res.sequence_res   = r_seq;
                    o_res.payload_type   = ptype_sub;
                    o_res.payload_length = r_len - TYPE_LEN;
                    if (csum_sub == r_rx_csum) begin
                        o_res.kind         = K_OK;
                        o_res.ack_required = (r_type == TYPE_MSG);
                        o_res.ack_received = (r_type == TYPE_ACK);
                        o_res.plain_ack    = (r_type == TYPE_ACK) &&
                                             (r_len == TYPE_LEN + 8'd1);
                    end else begin
                        o_res.kind = K_CSUM_ERR;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_HDR;
            r_cnt     <= '0;
            r_type    <= '0;
            r_seq     <= '0;
            r_len     <= '0;
            r_rx_csum <= '0;
            r_csum    <= CSUM_INIT;
            r_ptype   <= '0;
        end else if (i_take) begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_type    <= n_type;
            r_seq     <= n_seq;
            r_len     <= n_len;
            r_rx_csum <= n_rx_csum;
            r_csum    <= n_csum;
            r_ptype   <= n_ptype;
        end
    end

    a_body_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BODY |-> r_len != 8'd0)
        else $error("body entered with zero length");

    a_body_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BODY |-> r_cnt < r_len)
        else $error("body count ran past length");

    a_type_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEQ || r_state == S_BODY) |-> (r_type == TYPE_ACK || r_type == TYPE_MSG))
        else $error("frame type not ack or message");

endmodule

>>> rtl/core/uart_frame_receiver_top.sv
// channel   | handshake           | payload
// ----------+---------------------+---------------------------------------------
// rx in     | i_valid / o_stall   | i_rx_byte
// result    | o_valid / i_stall   | o_kind through o_plain_ack, one port per field
//
// one byte per cycle while o_stall is low; a result appears in the cycle after the byte
// that causes it is taken, held in the single result register behind the frame parser
// reset is synchronous, active low, and returns the parser to header search
// o_stall is high only while a result is held and the downstream stalls
module uart_frame_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data,
    output logic        o_data_valid,
    output logic [7:0]  o_payload_index,
    output logic [7:0]  o_packet_type,
    output logic [7:0]  o_sequence_res,
    output logic [23:0] o_payload_type,
    output logic [7:0]  o_payload_length,
    output logic        o_ack_required,
    output logic        o_ack_received,
    output logic        o_plain_ack
);
    import ufr_pkg::*;

    logic    take;
    t_result res;
    t_result r_out;
    logic    r_out_valid;

    assign o_stall = r_out_valid && i_stall;
    assign take    = i_valid && !o_stall;

    ufr_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_rx_byte),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res.valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload register, loaded on every input transfer
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_data           = r_out.data;
    assign o_data_valid     = r_out.data_valid;
    assign o_payload_index  = r_out.payload_index;
    assign o_packet_type    = r_out.packet_type;
    assign o_sequence_res   = r_out.sequence_res;
    assign o_payload_type   = r_out.payload_type;
    assign o_payload_length = r_out.payload_length;
    assign o_ack_required   = r_out.ack_required;
    assign o_ack_received   = r_out.ack_received;
    assign o_plain_ack      = r_out.plain_ack;

    a_data_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data_valid |->
            (o_kind == K_DATA || o_kind == K_OK || o_kind == K_CSUM_ERR))
        else $error("payload byte on a result kind that carries none");

    a_flag_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_ack_required || o_ack_received) |-> o_kind == K_OK)
        else $error("ack flag on a frame that is not ok");

    a_plain_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_plain_ack |-> o_ack_received && !o_ack_required)
        else $error("plain ack without ack received");

endmodule
